FILE: hw/rtl/io_latency_log2_histogram_unit_defines.svh
// assertion macros used by the latency histogram checker
`ifndef IO_LATENCY_LOG2_HISTOGRAM_UNIT_DEFINES_SVH
`define IO_LATENCY_LOG2_HISTOGRAM_UNIT_DEFINES_SVH

// checked property, disabled while reset is high
`define ILH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds through reset
`define ILH_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/iolh_pkg.sv
// types, codes and fixed constants of the latency histogram unit
package iolh_pkg;

   localparam int unsigned NS_PER_US = 1000;
   localparam int unsigned ACT_W     = 2;
   localparam int unsigned ID_W      = 10;
   localparam int unsigned TS_W      = 64;
   localparam int unsigned SEL_W     = 5;
   localparam int unsigned STAT_W    = 3;
   localparam int unsigned LAT_W     = 55;
   localparam int unsigned CNT_W     = 64;
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned DIV_STEPS = TS_W / DIGIT_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
   localparam int unsigned REM_W     = $clog2(NS_PER_US);
   localparam int unsigned LOG_W     = $clog2(TS_W);
   localparam int unsigned CAP_W     = LOG_W + 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_START    = 2'd0,
      ACT_COMPLETE = 2'd1,
      ACT_READ     = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_STORED   = 3'd0,
      STAT_COUNTED  = 3'd1,
      STAT_NO_START = 3'd2,
      STAT_NEG_DROP = 3'd3,
      STAT_READ     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STORE,
      ST_LOOKUP,
      ST_CHECK,
      ST_DIVIDE,
      ST_CNT_RD,
      ST_CNT_DONE
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       clear_wr;
      logic       store;
      logic       lookup;
      logic       check;
      logic       div_step;
      logic       cnt_read;
      logic       cnt_incr;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic entry_valid;
      logic diff_neg;
      logic div_last;
      logic is_complete;
   } stat_type;

   // floor log2 of one quotient digit, zero for zero
   function automatic logic [1:0] nib_log2(input logic [DIGIT_W-1:0] d);
      logic [1:0] r;
      case (d) inside
         4'b1???: r = 2'd3;
         4'b01??: r = 2'd2;
         4'b001?: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/iolh_ctrl.sv
// sequencer for table clear, store, lookup, divide and bucket read and update
module iolh_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [iolh_pkg::ACT_W-1:0] req_action,
   input  iolh_pkg::stat_type        stat,
   output iolh_pkg::cmd_type         cmd,
   output logic                      busy
);
   import iolh_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_START:    state_in = ST_STORE;
                  ACT_COMPLETE: state_in = ST_LOOKUP;
                  ACT_READ:     state_in = ST_CNT_RD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_STORE:  state_in = ST_IDLE;
         ST_LOOKUP: state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.entry_valid && !stat.diff_neg) state_in = ST_DIVIDE;
            else state_in = ST_IDLE;
         end
         ST_DIVIDE: begin
            if (stat.div_last) state_in = ST_CNT_RD;
         end
         ST_CNT_RD:   state_in = ST_CNT_DONE;
         ST_CNT_DONE: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE:  cmd.capture  = start;
         ST_STORE: begin
            cmd.store      = 1'b1;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = STAT_STORED;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (!stat.entry_valid) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_NO_START;
            end else if (stat.diff_neg) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = STAT_NEG_DROP;
            end
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_CNT_RD: cmd.cnt_read = 1'b1;
         ST_CNT_DONE: begin
            cmd.rsp_load = 1'b1;
            if (stat.is_complete) begin
               cmd.cnt_incr   = 1'b1;
               cmd.rsp_status = STAT_COUNTED;
            end else begin
               cmd.rsp_status = STAT_READ;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: hw/rtl/iolh_datapath.sv
// start table, radix-16 divider by 1000, bucket counters and result registers
module iolh_datapath #(
   parameter int unsigned TABLE_DEPTH  = 1024,
   parameter int unsigned BUCKET_TOTAL = 27
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [iolh_pkg::ACT_W-1:0]            req_action,
   input  logic [iolh_pkg::ID_W-1:0]             req_request_id,
   input  logic [iolh_pkg::TS_W-1:0]             req_timestamp_ns,
   input  logic [iolh_pkg::SEL_W-1:0]            req_bucket_index,
   input  iolh_pkg::cmd_type                    cmd,
   output iolh_pkg::stat_type                   stat,
   output logic                                 rsp_strobe,
   output logic [iolh_pkg::STAT_W-1:0]           rsp_status,
   output logic [$clog2(BUCKET_TOTAL)-1:0]      rsp_bucket,
   output logic [iolh_pkg::LAT_W-1:0]            rsp_latency_us,
   output logic [iolh_pkg::CNT_W-1:0]            rsp_count
);
   import iolh_pkg::*;

   localparam int unsigned AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned BW    = $clog2(BUCKET_TOTAL);
   localparam int unsigned MOD_W = AW + 1;
   localparam int unsigned VAL_W = REM_W + DIGIT_W;
   localparam logic [MOD_W-1:0] DEPTH_C     = MOD_W'(TABLE_DEPTH);
   localparam logic [AW-1:0]    CLEAR_LAST  = AW'(TABLE_DEPTH - 1);
   localparam logic [CAP_W-1:0] BUCKET_LAST = CAP_W'(BUCKET_TOTAL - 1);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(DIV_STEPS - 1);

   // start table entry: valid bit above the timestamp
   logic [TS_W:0]  start_mem [TABLE_DEPTH];
   logic [CNT_W-1:0] count_mem [BUCKET_TOTAL];

   logic [ACT_W-1:0]  act_ff;
   logic [AW-1:0]     slot_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [BW-1:0]     bucket_ff;
   logic [AW-1:0]     clr_ff;
   logic [TS_W:0]     rd_ff;
   logic [TS_W-1:0]   div_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [LAT_W-1:0]  quot_ff;
   logic [STEP_W-1:0] step_ff;
   logic              found_ff;
   logic [LOG_W-1:0]  log2_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic              cnt_hit_ff;
   logic [BUCKET_TOTAL-1:0] cnt_vld_ff;
   logic              rsp_strobe_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [BW-1:0]     rsp_bucket_ff;
   logic [LAT_W-1:0]  rsp_latency_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic [MOD_W-1:0]  mod_rem;
   logic [CAP_W-1:0]  sel_wide, sel_cap, log_wide, log_cap;
   logic [TS_W-1:0]   diff;
   logic [VAL_W-1:0]  div_val, div_sub;
   logic [DIGIT_W-1:0] digit;
   logic [REM_W-1:0]  rem_in;
   logic [LOG_W-1:0]  log2_in;
   logic [BW-1:0]     cnt_addr;
   logic [CNT_W-1:0]  cnt_cur, cnt_new;
   logic              tbl_we;
   logic [AW-1:0]     tbl_waddr;
   logic [TS_W:0]     tbl_wdata;

   // request id reduced modulo the table depth, one bit at a time
   always_comb begin
      mod_rem = '0;
      for (int i = ID_W - 1; i >= 0; i--) begin
         mod_rem = {mod_rem[MOD_W-2:0], req_request_id[i]};
         if (mod_rem >= DEPTH_C) mod_rem = mod_rem - DEPTH_C;
      end
   end

   assign sel_wide = CAP_W'(req_bucket_index);
   assign sel_cap  = (sel_wide > BUCKET_LAST) ? BUCKET_LAST : sel_wide;
   assign log_wide = CAP_W'(log2_ff);
   assign log_cap  = (log_wide > BUCKET_LAST) ? BUCKET_LAST : log_wide;

   assign diff = ts_ff - rd_ff[TS_W-1:0];

   // one quotient digit per step: compare against the multiples of 1000
   always_comb begin
      div_val = {rem_ff, div_ff[TS_W-1 -: DIGIT_W]};
      digit   = '0;
      div_sub = '0;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (div_val >= VAL_W'(k * NS_PER_US)) begin
            digit   = DIGIT_W'(k);
            div_sub = VAL_W'(k * NS_PER_US);
         end
      end
      rem_in  = REM_W'(div_val - div_sub);
      log2_in = {~step_ff, 2'b00} + LOG_W'(nib_log2(digit));
   end

   assign cnt_addr = (act_ff == ACT_COMPLETE) ? log_cap[BW-1:0] : bucket_ff;
   assign cnt_cur  = cnt_hit_ff ? cnt_rd_ff : '0;
   assign cnt_new  = cnt_cur + CNT_W'(1);

   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = slot_ff;
      tbl_wdata = {1'b0, rd_ff[TS_W-1:0]};
      if (cmd.clear_wr) begin
         tbl_we    = 1'b1;
         tbl_waddr = clr_ff;
         tbl_wdata = '0;
      end else if (cmd.store) begin
         tbl_we    = 1'b1;
         tbl_wdata = {1'b1, ts_ff};
      end else if (cmd.check) begin
         tbl_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) start_mem[tbl_waddr] <= tbl_wdata;
      if (cmd.lookup) rd_ff <= start_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_incr) count_mem[bucket_ff] <= cnt_new;
      if (cmd.cnt_read) cnt_rd_ff <= count_mem[cnt_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         cnt_vld_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_ff + AW'(1);
         if (cmd.cnt_incr) cnt_vld_ff[bucket_ff] <= 1'b1;
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff    <= req_action;
         slot_ff   <= mod_rem[AW-1:0];
         ts_ff     <= req_timestamp_ns;
         bucket_ff <= sel_cap[BW-1:0];
      end
      if (cmd.check) begin
         div_ff   <= diff;
         rem_ff   <= '0;
         quot_ff  <= '0;
         step_ff  <= '0;
         found_ff <= 1'b0;
         log2_ff  <= '0;
      end
      if (cmd.div_step) begin
         div_ff  <= {div_ff[TS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[LAT_W-DIGIT_W-1:0], digit};
         step_ff <= step_ff + STEP_W'(1);
         // leading digit fixes the log2 of the quotient
         if (!found_ff && (digit != '0)) begin
            found_ff <= 1'b1;
            log2_ff  <= log2_in;
         end
      end
      if (cmd.cnt_read) begin
         bucket_ff  <= cnt_addr;
         cnt_hit_ff <= cnt_vld_ff[cnt_addr];
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         case (cmd.rsp_status)
            STAT_COUNTED: begin
               rsp_bucket_ff  <= bucket_ff;
               rsp_latency_ff <= quot_ff;
               rsp_count_ff   <= cnt_new;
            end
            STAT_READ: begin
               rsp_bucket_ff  <= bucket_ff;
               rsp_latency_ff <= '0;
               rsp_count_ff   <= cnt_cur;
            end
            default: begin
               rsp_bucket_ff  <= '0;
               rsp_latency_ff <= '0;
               rsp_count_ff   <= '0;
            end
         endcase
      end
   end

   assign stat.clear_last  = (clr_ff == CLEAR_LAST);
   assign stat.entry_valid = rd_ff[TS_W];
   assign stat.diff_neg    = diff[TS_W-1];
   assign stat.div_last    = (step_ff == STEP_LAST);
   assign stat.is_complete = (act_ff == ACT_COMPLETE);

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_latency_us = rsp_latency_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

FILE: hw/rtl/io_latency_log2_histogram_unit.sv
// top level of the request latency log2 histogram unit
// After reset the unit sweeps its start table with busy high, one entry a cycle,
// and then takes one event at a time when start is high and busy is low. A start
// event gives its result beat after the store state, and a bucket read after the
// counter read and done states; a complete event runs table read, subtract, 16
// radix-16 digit steps of the divide by 1000, counter read and update to its beat
// when the entry is present, and gives its beat after the subtract check when it
// is absent or the elapsed time is negative. Events with action 3 are taken and
// give no beat. Each result is on the rsp_ ports for exactly one cycle under
// rsp_strobe and cannot be held off; busy is low in that cycle.
module io_latency_log2_histogram_unit #(
   parameter int unsigned TABLE_DEPTH  = 1024,
   parameter int unsigned BUCKET_TOTAL = 27
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [iolh_pkg::ACT_W-1:0]       req_action,
   input  logic [iolh_pkg::ID_W-1:0]        req_request_id,
   input  logic [iolh_pkg::TS_W-1:0]        req_timestamp_ns,
   input  logic [iolh_pkg::SEL_W-1:0]       req_bucket_index,
   output logic                            rsp_strobe,
   output logic [iolh_pkg::STAT_W-1:0]      rsp_status,
   output logic [$clog2(BUCKET_TOTAL)-1:0] rsp_bucket,
   output logic [iolh_pkg::LAT_W-1:0]       rsp_latency_us,
   output logic [iolh_pkg::CNT_W-1:0]       rsp_count
);
   import iolh_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   iolh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   iolh_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .BUCKET_TOTAL (BUCKET_TOTAL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_request_id   (req_request_id),
      .req_timestamp_ns (req_timestamp_ns),
      .req_bucket_index (req_bucket_index),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_bucket       (rsp_bucket),
      .rsp_latency_us   (rsp_latency_us),
      .rsp_count        (rsp_count)
   );

endmodule

FILE: hw/rtl/iolh_checker.sv
// port-level checks of the latency histogram unit and their binding
`include "io_latency_log2_histogram_unit_defines.svh"

module iolh_checker #(
   parameter int unsigned BUCKET_TOTAL = 27
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [iolh_pkg::ACT_W-1:0]       req_action,
   input logic                            rsp_strobe,
   input logic [iolh_pkg::STAT_W-1:0]      rsp_status,
   input logic [$clog2(BUCKET_TOTAL)-1:0] rsp_bucket,
   input logic [iolh_pkg::LAT_W-1:0]       rsp_latency_us
);
   import iolh_pkg::*;

   `ILH_ASSERT_NR(a_reset_busy, clock, reset |=> busy, "busy low right after reset")
   `ILH_ASSERT(a_beat_single, clock, reset, rsp_strobe |=> !rsp_strobe, "result beat longer than one cycle")
   `ILH_ASSERT(a_accept_busy, clock, reset, (start && !busy && (req_action == ACT_START || req_action == ACT_COMPLETE || req_action == ACT_READ)) |=> busy, "event accepted without going busy")
   `ILH_ASSERT(a_latency_zero, clock, reset, (rsp_strobe && rsp_status != STAT_COUNTED) |-> rsp_latency_us == '0, "latency set on an uncounted beat")
   `ILH_ASSERT(a_bucket_range, clock, reset, rsp_strobe |-> rsp_bucket < BUCKET_TOTAL, "bucket beyond the last one")

endmodule

bind io_latency_log2_histogram_unit iolh_checker #(.BUCKET_TOTAL(BUCKET_TOTAL)) u_checker (.*);
